// ===== hdl/cddd_pkg.sv =====
// Shared types, constants and calendar tables for the date difference unit.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package cddd_pkg;

    // Field widths fixed by the interface.
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int DNUM_W   = 22;
    localparam int YDAYS_W  = 23;
    localparam int DOY_W    = 9;

    // Register stages from the input transfer to the result strobe.
    localparam int PIPE_DEPTH = 4;

    // Calendar limits.
    localparam logic [YEAR_W-1:0]  MAX_YEAR  = YEAR_W'(9999);
    localparam logic [MONTH_W-1:0] MAX_MONTH = MONTH_W'(12);
    localparam logic [MONTH_W-1:0] FEBRUARY  = MONTH_W'(2);

    // Reciprocal of 100: floor(p / 100) == (p * RECIP_100) >> RECIP_SHIFT for any 14-bit p.
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD100_W   = YEAR_W + 13;
    localparam int Q100_W      = PROD100_W - RECIP_SHIFT;
    localparam int DAYS_PER_YEAR = 365;

    // Per-date status code.
    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_BAD_YEAR  = 2'd1,
        ST_BAD_MONTH = 2'd2,
        ST_BAD_DAY   = 2'd3
    } t_status;

    // Result of one date path.
    typedef struct packed {
        logic [DNUM_W-1:0] day_num;
        t_status           status;
    } t_date_info;

    // Length of a month; zero for a month code outside 1 to 12.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
            4'd2:    len = leap ? DAY_W'(29) : DAY_W'(28);
            default: len = '0;
        endcase
        return len;
    endfunction

    // Days in the months before month m of a common year.
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] n;
        case (m)
            4'd1:    n = DOY_W'(0);
            4'd2:    n = DOY_W'(31);
            4'd3:    n = DOY_W'(59);
            4'd4:    n = DOY_W'(90);
            4'd5:    n = DOY_W'(120);
            4'd6:    n = DOY_W'(151);
            4'd7:    n = DOY_W'(181);
            4'd8:    n = DOY_W'(212);
            4'd9:    n = DOY_W'(243);
            4'd10:   n = DOY_W'(273);
            4'd11:   n = DOY_W'(304);
            4'd12:   n = DOY_W'(334);
            default: n = '0;
        endcase
        return n;
    endfunction

endpackage

// ===== hdl/cddd_day_number.sv =====
// Three-stage pipeline that checks one date and converts it to a day number.
// Depends on cddd_pkg for widths, status codes and the month tables.
`timescale 1ns / 1ps

module cddd_day_number
    import cddd_pkg::*;
(
    input  logic               i_clk,
    input  logic [DAY_W-1:0]   i_day,
    input  logic [MONTH_W-1:0] i_month,
    input  logic [YEAR_W-1:0]  i_year,
    output t_date_info         o_info
);

    // Stage 1 registers.
    logic [YEAR_W-1:0]    r_p;
    logic [PROD100_W-1:0] r_prod100;
    logic [YDAYS_W-1:0]   r_prod365;
    logic [DAY_W-1:0]     r_day1;
    logic [MONTH_W-1:0]   r_month1;
    logic                 r_yr_bad;
    logic                 r_mo_bad;

    // Stage 2 registers.
    logic [YDAYS_W-1:0]   r_year_days;
    logic [DOY_W-1:0]     r_doy;
    t_status              r_status2;

    // Stage 2 logic.
    logic [Q100_W-1:0]    q100;
    logic [6:0]           rem100;
    logic                 leap;
    logic                 late_month;
    logic [DAY_W-1:0]     len;
    logic [YEAR_W-1:0]    n_p;
    t_status              n_status2;

    // Stage 1: elapsed years, the two constant products and the range checks.
    assign n_p = i_year - YEAR_W'(1);

    always_ff @(posedge i_clk) begin
        r_p       <= n_p;
        r_prod100 <= PROD100_W'(n_p) * PROD100_W'(RECIP_100);
        r_prod365 <= YDAYS_W'(n_p) * YDAYS_W'(DAYS_PER_YEAR);
        r_day1    <= i_day;
        r_month1  <= i_month;
        r_yr_bad  <= (i_year == '0) || (i_year > MAX_YEAR);
        r_mo_bad  <= (i_month == '0) || (i_month > MAX_MONTH);
    end

    // Stage 2: the year is leap when p ends in 3 mod 4, unless p is 99 mod 100
    // and the hundreds count of p is not 3 mod 4.
    assign q100       = r_prod100[PROD100_W-1:RECIP_SHIFT];
    assign rem100     = 7'(r_p - YEAR_W'(q100) * YEAR_W'(100));
    assign leap       = (r_p[1:0] == 2'b11) && ((rem100 != 7'd99) || (q100[1:0] == 2'b11));
    assign late_month = r_month1 > FEBRUARY;
    assign len        = month_len(r_month1, leap);

    always_comb begin
        if (r_yr_bad) begin
            n_status2 = ST_BAD_YEAR;
        end else if (r_mo_bad) begin
            n_status2 = ST_BAD_MONTH;
        end else if ((r_day1 == '0) || (r_day1 > len)) begin
            n_status2 = ST_BAD_DAY;
        end else begin
            n_status2 = ST_VALID;
        end
    end

    always_ff @(posedge i_clk) begin
        r_year_days <= r_prod365 + YDAYS_W'(r_p >> 2) - YDAYS_W'(q100)
                       + YDAYS_W'(q100 >> 2);
        r_doy       <= days_before(r_month1) + DOY_W'(leap && late_month)
                       + DOY_W'(r_day1);
        r_status2   <= n_status2;
    end

    // Stage 3: day number of the date.
    always_ff @(posedge i_clk) begin
        o_info.day_num <= DNUM_W'(r_year_days + YDAYS_W'(r_doy));
        o_info.status  <= r_status2;
    end

endmodule

// ===== hdl/calendar_date_day_difference_unit.sv =====
// An item enters at the transfer at start; o_done is high when its valid bit reaches the last stage.
// Throughput: one item per cycle; busy stays low, since the four-stage pipeline always
// advances and the receiver cannot stall.
// Stages: year products, leap and status, day number, absolute difference.
// Reset (synchronous, active low) clears the valid bits; items in flight are dropped and no result is invented.
`timescale 1ns / 1ps

module calendar_date_day_difference_unit
    import cddd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [DAY_W-1:0]   i_first_day,
    input  logic [MONTH_W-1:0] i_first_month,
    input  logic [YEAR_W-1:0]  i_first_year,
    input  logic [DAY_W-1:0]   i_second_day,
    input  logic [MONTH_W-1:0] i_second_month,
    input  logic [YEAR_W-1:0]  i_second_year,
    output logic               o_done,
    output logic [DNUM_W-1:0]  o_day_difference,
    output logic [1:0]         o_first_status,
    output logic [1:0]         o_second_status
);

    t_date_info            first_info;
    t_date_info            second_info;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [DNUM_W:0]       diff_ab;
    logic [DNUM_W-1:0]     n_diff;
    logic [DNUM_W-1:0]     r_diff;
    t_status               r_st1;
    t_status               r_st2;

    // One date path per date.
    cddd_day_number u_first (
        .i_clk   (i_clk),
        .i_day   (i_first_day),
        .i_month (i_first_month),
        .i_year  (i_first_year),
        .o_info  (first_info)
    );

    cddd_day_number u_second (
        .i_clk   (i_clk),
        .i_day   (i_second_day),
        .i_month (i_second_month),
        .i_year  (i_second_year),
        .o_info  (second_info)
    );

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_start};
        end
    end

    // Stage 4: absolute difference, forced to zero when either date is bad.
    assign diff_ab = {1'b0, first_info.day_num} - {1'b0, second_info.day_num};

    always_comb begin
        if ((first_info.status != ST_VALID) || (second_info.status != ST_VALID)) begin
            n_diff = '0;
        end else if (diff_ab[DNUM_W]) begin
            n_diff = second_info.day_num - first_info.day_num;
        end else begin
            n_diff = diff_ab[DNUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff <= n_diff;
        r_st1  <= first_info.status;
        r_st2  <= second_info.status;
    end

    assign o_busy           = 1'b0;
    assign o_done           = r_vld[PIPE_DEPTH-1];
    assign o_day_difference = r_diff;
    assign o_first_status   = r_st1;
    assign o_second_status  = r_st2;

endmodule

// ===== hdl/cddd_checker.sv =====
// Port-level checks for the date difference unit, bound to its top level.
// Depends on cddd_pkg for widths.
`timescale 1ns / 1ps

module cddd_checker
    import cddd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input logic              o_done,
    input logic [DNUM_W-1:0] o_day_difference,
    input logic [1:0]        o_first_status,
    input logic [1:0]        o_second_status
);

    // Every accepted transfer yields a result once it has passed through the pipeline.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##PIPE_DEPTH o_done)
        else $error("accepted item produced no result");

    // No result appears without a matching accepted transfer.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, PIPE_DEPTH))
        else $error("result without an accepted item");

    // A bad date forces a zero difference.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ((o_first_status != ST_VALID) || (o_second_status != ST_VALID)))
            |-> (o_day_difference == '0))
        else $error("nonzero difference with a bad date");

    // The difference stays inside the calendar span.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_day_difference <= DNUM_W'(3652058)))
        else $error("difference out of range");

endmodule

bind calendar_date_day_difference_unit cddd_checker u_cddd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_start          (i_start),
    .o_busy           (o_busy),
    .o_done           (o_done),
    .o_day_difference (o_day_difference),
    .o_first_status   (o_first_status),
    .o_second_status  (o_second_status)
);

// ===== verif/calendar_date_day_difference_unit_tb.sv =====
// Self-checking testbench for calendar_date_day_difference_unit: directed and random date pairs,
// a clocked driver and monitor, and a predictor of day differences and date statuses.
// Depends on cddd_pkg and the calendar_date_day_difference_unit RTL.
`timescale 1ns / 1ps

module calendar_date_day_difference_unit_tb;
    import cddd_pkg::*;

    // One date pair waiting to be driven, with the pacing that goes with it.
    typedef struct {
        logic [DAY_W-1:0]   first_day;
        logic [MONTH_W-1:0] first_month;
        logic [YEAR_W-1:0]  first_year;
        logic [DAY_W-1:0]   second_day;
        logic [MONTH_W-1:0] second_month;
        logic [YEAR_W-1:0]  second_year;
        int unsigned        gap_pct;
        bit                 drain_first;
    } t_date_pair;

    // Expected outcome of one date pair.
    typedef struct {
        logic [DNUM_W-1:0] days;
        t_status           first_status;
        t_status           second_status;
    } t_day_gap;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic [DAY_W-1:0]   i_first_day = '0;
    logic [MONTH_W-1:0] i_first_month = '0;
    logic [YEAR_W-1:0]  i_first_year = '0;
    logic [DAY_W-1:0]   i_second_day = '0;
    logic [MONTH_W-1:0] i_second_month = '0;
    logic [YEAR_W-1:0]  i_second_year = '0;
    logic               o_done;
    logic [DNUM_W-1:0]  o_day_difference;
    logic [1:0]         o_first_status;
    logic [1:0]         o_second_status;

    t_date_pair  pending_pairs[$];
    t_day_gap    expected_gaps[$];
    int unsigned mismatches = 0;

    calendar_date_day_difference_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_first_day      (i_first_day),
        .i_first_month    (i_first_month),
        .i_first_year     (i_first_year),
        .i_second_day     (i_second_day),
        .i_second_month   (i_second_month),
        .i_second_year    (i_second_year),
        .o_done           (o_done),
        .o_day_difference (o_day_difference),
        .o_first_status   (o_first_status),
        .o_second_status  (o_second_status)
    );

    // Free-running 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Gregorian leap rule.
    function automatic bit is_leap(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // Length of month m (1 to 12) in year y.
    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        case (m)
            2:          return is_leap(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:    return 31;
        endcase
    endfunction

    // Status of one date; faults are looked for in the order year, month, day.
    function automatic t_status date_check(input int unsigned d, input int unsigned m,
                                           input int unsigned y);
        if (y == 0 || y > MAX_YEAR)
            return ST_BAD_YEAR;
        if (m == 0 || m > MAX_MONTH)
            return ST_BAD_MONTH;
        if (d == 0 || d > month_days(m, y))
            return ST_BAD_DAY;
        return ST_VALID;
    endfunction

    // Days from the start of the calendar up to and including a valid date.
    function automatic int unsigned day_number(input int unsigned d, input int unsigned m,
                                               input int unsigned y);
        int unsigned prior;
        int unsigned n;
        prior = y - 1;
        n = prior * 365 + prior / 4 - prior / 100 + prior / 400;
        // Earlier months are summed over a common year; the leap day is added after.
        for (int unsigned k = 1; k < m; k++)
            n += month_days(k, 1);
        if (m > 2 && is_leap(y))
            n += 1;
        return n + d;
    endfunction

    // Expected outcome for one pair of dates.
    function automatic t_day_gap predict_difference(input t_date_pair p);
        t_day_gap    r;
        int unsigned a;
        int unsigned b;
        r.first_status  = date_check(p.first_day, p.first_month, p.first_year);
        r.second_status = date_check(p.second_day, p.second_month, p.second_year);
        r.days = '0;
        if (r.first_status == ST_VALID && r.second_status == ST_VALID) begin
            a = day_number(p.first_day, p.first_month, p.first_year);
            b = day_number(p.second_day, p.second_month, p.second_year);
            r.days = DNUM_W'((a > b) ? a - b : b - a);
        end
        return r;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic note_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Random date, either well formed or broken in one of several ways.
    function automatic void pick_date(input bit well_formed, output logic [DAY_W-1:0] d,
                                      output logic [MONTH_W-1:0] m,
                                      output logic [YEAR_W-1:0] y);
        int unsigned len;
        // Years lean toward century, leap and boundary years.
        case ($urandom_range(5))
            0:       y = YEAR_W'($urandom_range(1, 99) * 100);
            1:       y = YEAR_W'($urandom_range(1, 2499) * 4);
            2:       y = YEAR_W'($urandom_range(1, 4));
            3:       y = YEAR_W'($urandom_range(9995, 9999));
            4:       y = YEAR_W'($urandom_range(1880, 2120));
            default: y = YEAR_W'($urandom_range(1, 9999));
        endcase
        m = MONTH_W'($urandom_range(1, 12));
        len = month_days(m, y);
        d = DAY_W'($urandom_range(1, len));
        if (!well_formed) begin
            case ($urandom_range(4))
                0: begin
                    d = DAY_W'($urandom);
                    m = MONTH_W'($urandom);
                    y = YEAR_W'($urandom);
                end
                1: d = DAY_W'(len + 1);
                2: m = $urandom_range(1) ? MONTH_W'($urandom_range(13, 15)) : '0;
                3: y = $urandom_range(1) ? YEAR_W'($urandom_range(10000, 16383)) : '0;
                default: begin
                    m = FEBRUARY;
                    d = DAY_W'(29);
                end
            endcase
        end
    endfunction

    // Queues one directed pair with no gap before it.
    task automatic add_pair(input int unsigned d1, input int unsigned m1, input int unsigned y1,
                            input int unsigned d2, input int unsigned m2, input int unsigned y2);
        t_date_pair p;
        p.first_day    = DAY_W'(d1);
        p.first_month  = MONTH_W'(m1);
        p.first_year   = YEAR_W'(y1);
        p.second_day   = DAY_W'(d2);
        p.second_month = MONTH_W'(m2);
        p.second_year  = YEAR_W'(y2);
        p.gap_pct      = 0;
        p.drain_first  = 1'b0;
        pending_pairs.push_back(p);
    endtask

    // Driver: records each transfer and presents the next pair when pacing allows.
    always @(posedge i_clk) begin
        logic       taken;
        t_date_pair cur;
        t_date_pair nxt;
        taken = i_start && !o_busy;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (taken) begin
                cur.first_day    = i_first_day;
                cur.first_month  = i_first_month;
                cur.first_year   = i_first_year;
                cur.second_day   = i_second_day;
                cur.second_month = i_second_month;
                cur.second_year  = i_second_year;
                expected_gaps.push_back(predict_difference(cur));
            end
            if (i_start && !taken) begin
                // Hold the pair until the block takes it.
            end else if (pending_pairs.size() > 0
                         && !(pending_pairs[0].drain_first && expected_gaps.size() > 0)
                         && $urandom_range(99) >= pending_pairs[0].gap_pct) begin
                nxt = pending_pairs.pop_front();
                i_first_day    <= nxt.first_day;
                i_first_month  <= nxt.first_month;
                i_first_year   <= nxt.first_year;
                i_second_day   <= nxt.second_day;
                i_second_month <= nxt.second_month;
                i_second_year  <= nxt.second_year;
                i_start        <= 1'b1;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // Monitor: each strobed result is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_day_gap want;
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_gaps.size() == 0) begin
                note_mismatch("result with no transfer pending");
            end else begin
                want = expected_gaps.pop_front();
                if (o_day_difference !== want.days)
                    note_mismatch($sformatf("day_difference got %0d expected %0d",
                                            o_day_difference, want.days));
                if (o_first_status !== want.first_status)
                    note_mismatch($sformatf("first_status got %0d expected %0d",
                                            o_first_status, want.first_status));
                if (o_second_status !== want.second_status)
                    note_mismatch($sformatf("second_status got %0d expected %0d",
                                            o_second_status, want.second_status));
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        t_date_pair  p;
        int unsigned gap_of_phase[3];
        gap_of_phase = '{0, 66, 22};

        // Directed pairs: extremes, each fault kind, leap-day edges.
        add_pair(1, 1, 1, 1, 1, 1);
        add_pair(1, 1, 1, 31, 12, 9999);
        add_pair(31, 12, 9999, 1, 1, 1);
        add_pair(1, 1, 0, 1, 1, 1);
        add_pair(1, 1, 1, 1, 1, 10000);
        add_pair(0, 0, 16383, 0, 15, 9999);
        add_pair(1, 0, 2000, 1, 13, 2000);
        add_pair(0, 15, 2000, 0, 1, 2000);
        add_pair(31, 4, 2021, 31, 12, 2021);
        add_pair(29, 2, 2000, 29, 2, 1900);
        add_pair(29, 2, 2004, 29, 2, 2001);
        add_pair(30, 2, 2000, 28, 2, 1900);
        add_pair(28, 2, 2000, 1, 3, 2000);
        add_pair(1, 3, 1900, 28, 2, 1900);
        add_pair(31, 12, 1999, 1, 1, 2000);
        add_pair(31, 15, 16383, 31, 15, 16383);
        add_pair(15, 6, 1987, 0, 6, 1987);
        add_pair(1, 1, 9999, 31, 12, 9998);
        add_pair(29, 2, 400, 1, 3, 400);
        add_pair(31, 1, 1, 31, 3, 1600);

        // Random phases: no gaps, frequent gaps, occasional gaps.
        for (int ph = 0; ph < 3; ph++) begin
            for (int n = 0; n < 634; n++) begin
                if ($urandom_range(99) < 75) begin
                    pick_date(1'b1, p.first_day, p.first_month, p.first_year);
                    if ($urandom_range(19) == 0) begin
                        p.second_day   = p.first_day;
                        p.second_month = p.first_month;
                        p.second_year  = p.first_year;
                    end else begin
                        pick_date(1'b1, p.second_day, p.second_month, p.second_year);
                    end
                end else begin
                    pick_date($urandom_range(1), p.first_day, p.first_month, p.first_year);
                    pick_date($urandom_range(1), p.second_day, p.second_month, p.second_year);
                end
                p.gap_pct = gap_of_phase[ph];
                p.drain_first = (n == 0) || ($urandom_range(99) == 0);
                pending_pairs.push_back(p);
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_pairs.size() != 0 || i_start)
            @(posedge i_clk);
        while (expected_gaps.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        // Every transfer must have produced its result by now.
        if (expected_gaps.size() != 0)
            note_mismatch("transfer left without a result");

        if (mismatches == 0)
            $display("[calendar_date_day_difference_unit] OK");
        else
            $display("[calendar_date_day_difference_unit] ERROR");
        $finish;
    end

    // Watchdog on the whole run.
    initial begin
        #2000000;
        $display("[calendar_date_day_difference_unit] ERROR");
        $finish;
    end

endmodule

// ===== calendar_date_day_difference_unit.f =====
hdl/cddd_pkg.sv
hdl/cddd_day_number.sv
hdl/calendar_date_day_difference_unit.sv
hdl/cddd_checker.sv
verif/calendar_date_day_difference_unit_tb.sv
